/* design/adcpd_pkg.sv */
// Types and fixed constants for the ADC encoder pinch detector.
// No dependencies; imported by every design file.
package adcpd_pkg;

    localparam int NUM_CH      = 6;
    localparam int SAMPLE_W    = 12;
    localparam int CHANNEL_W   = 3;
    localparam int SUM_W       = 18;
    localparam int AVG_W       = 12;
    localparam int COUNT_W     = 8;
    localparam int DIFF_W      = AVG_W + 1;
    localparam int D_W         = 22;
    localparam int MAX_SAMPLES = 64;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [AVG_W-1:0]   AVG_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic signed [D_W-1:0] DEG_PER_TURN = D_W'(360);

    localparam int STROKE_W    = 9;
    localparam int TOLERANCE_W = 7;
    localparam int REQUIRED_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_STROKE_RANGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRED     = 2'd2;

    localparam logic [STROKE_W-1:0]    STROKE_RESET    = 9'd30;
    localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET = 7'd4;
    localparam logic [REQUIRED_W-1:0]  REQUIRED_RESET  = 8'd2;

    localparam logic [CHANNEL_W-1:0] PINCH_CH_A = 3'd4;
    localparam logic [CHANNEL_W-1:0] PINCH_CH_B = 3'd5;

    typedef enum logic [1:0] {
        PINCH_REST     = 2'd0,
        PINCH_CLOSING  = 2'd1,
        PINCH_SQUEEZED = 2'd2,
        PINCH_OPENING  = 2'd3
    } pinch_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [CHANNEL_W-1:0] channel;
        logic                 frame_end;
    } sample_word_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_ch0;
        logic [AVG_W-1:0]   avg_ch1;
        logic [AVG_W-1:0]   avg_ch2;
        logic [AVG_W-1:0]   avg_ch3;
        logic [AVG_W-1:0]   avg_ch4;
        logic [AVG_W-1:0]   avg_ch5;
        pinch_state_t       pinch_state_a;
        pinch_state_t       pinch_state_b;
        logic [COUNT_W-1:0] squeeze_count_a;
        logic [COUNT_W-1:0] squeeze_count_b;
        logic               both_done;
    } result_word_t;

    typedef struct packed {
        pinch_state_t       state;
        logic [COUNT_W-1:0] count;
    } pinch_status_t;

endpackage

/* design/adcpd_detector.sv */
// Four-state pinch detector with saturating squeeze counter for one pincher.
// Depends on adcpd_pkg.
module adcpd_detector #(
    parameter int RANGE_W = 21,
    parameter int TOL_W   = 19
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic signed [adcpd_pkg::D_W-1:0] offset,
    input  logic [RANGE_W-1:0]              range,
    input  logic [TOL_W-1:0]                tol,
    output adcpd_pkg::pinch_status_t        status
);
    import adcpd_pkg::*;

    localparam int CMP_W = ((RANGE_W > D_W) ? RANGE_W : D_W) + 2;

    pinch_state_t       state_reg;
    pinch_state_t       state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic signed [CMP_W-1:0] d_x;
    logic signed [CMP_W-1:0] two_d;
    logic signed [CMP_W-1:0] r_x;
    logic signed [CMP_W-1:0] tol_x;
    logic signed [CMP_W-1:0] sq_off;
    logic signed [CMP_W-1:0] sq_abs;
    logic signed [CMP_W-1:0] rest_abs;
    logic                    close_cross;
    logic                    open_cross;
    logic                    at_squeezed;
    logic                    at_rest;

    always_comb
    begin
        d_x         = CMP_W'(offset);
        two_d       = d_x <<< 1;
        r_x         = $signed(CMP_W'(range));
        tol_x       = $signed(CMP_W'(tol));
        sq_off      = r_x - d_x;
        sq_abs      = sq_off[CMP_W-1] ? -sq_off : sq_off;
        rest_abs    = d_x[CMP_W-1] ? -d_x : d_x;
        close_cross = two_d > r_x;
        open_cross  = two_d < r_x;
        at_squeezed = sq_abs < tol_x;
        at_rest     = rest_abs < tol_x;
    end

    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            case (state_reg)
                PINCH_REST:     if (close_cross) state_next = PINCH_CLOSING;
                PINCH_CLOSING:  if (at_squeezed) state_next = PINCH_SQUEEZED;
                PINCH_SQUEEZED: if (open_cross)  state_next = PINCH_OPENING;
                PINCH_OPENING:  if (at_rest)     state_next = PINCH_REST;
                default:        state_next = PINCH_REST;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (step && state_reg == PINCH_CLOSING && at_squeezed && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        status.state = state_next;
        status.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PINCH_REST;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/adc_encoder_pinch_detector.sv */
// Top level of the ADC encoder pinch detector: per-channel sums, frame averages, pinch tracking.
// Depends on adcpd_pkg and adcpd_detector.
//
// Usage:
//   sample channel: one word per converter reading (sample, channel, frame_end), taken at a
//   rising edge with sample_valid high and sample_stall low. Readings tagged channel six or
//   seven are dropped but their frame_end still closes the frame.
//   result channel: one word per frame_end, taken with result_valid high and result_stall low.
//   cfg channel: register writes (index, data); cfg_ready is always high. Write only while idle.
//   Throughput: one sample word per cycle while sample_stall is low. A frame_end word passes
//   four registers in order: sum capture, reciprocal-multiply averaging, offset from rest,
//   detector step; the last of them drives result_word.
//   When the receiver stalls, the result register holds its word and the stages behind it fill;
//   sample_stall rises only once all four stages hold a result. Words without frame_end only
//   accumulate and never block beyond that.
//   Reset clears the sums, the rest capture, both detectors and counters, and loads the
//   register reset values. The first frame after reset records the rest angles and reports
//   both pinchers at rest with zero counts.
module adc_encoder_pinch_detector #(
    parameter int SAMPLES_PER_CHANNEL = 50,
    parameter int ADC_FULL_SCALE      = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  adcpd_pkg::sample_word_t             sample_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output adcpd_pkg::result_word_t             result_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adcpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [adcpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import adcpd_pkg::*;

    localparam int FS_W      = $clog2(ADC_FULL_SCALE + 1);
    localparam int RANGE_W   = STROKE_W + FS_W;
    localparam int TOL_W     = TOLERANCE_W + FS_W;
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_CHANNEL);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_CHANNEL) - 64'd1)
                 / 64'(SAMPLES_PER_CHANNEL));

    logic [STROKE_W-1:0]    stroke_reg;
    logic [TOLERANCE_W-1:0] tolerance_reg;
    logic [REQUIRED_W-1:0]  required_reg;
    logic [RANGE_W-1:0]     range_reg;
    logic [TOL_W-1:0]       tol_reg;

    logic [SUM_W-1:0] sum_reg    [NUM_CH];
    logic [SUM_W-1:0] sum_next   [NUM_CH];
    logic [SUM_W-1:0] s1_sum_reg [NUM_CH];
    logic [AVG_W-1:0] avg_next   [NUM_CH];
    logic [AVG_W-1:0] s2_avg_reg [NUM_CH];
    logic [AVG_W-1:0] s3_avg_reg [NUM_CH];

    logic [AVG_W-1:0]        rest_reg   [2];
    logic signed [D_W-1:0]   d_next     [2];
    logic signed [D_W-1:0]   s3_d_reg   [2];
    logic                    captured_reg;
    logic                    s3_first_reg;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic result_valid_reg;
    logic s1_free;
    logic s2_free;
    logic s3_free;
    logic out_free;
    logic accept;
    logic s2_move;
    logic s3_move;
    logic det_step;

    result_word_t  result_word_reg;
    pinch_status_t status_a;
    pinch_status_t status_b;

    assign out_free     = !result_valid_reg || !result_stall;
    assign s3_free      = !s3_valid_reg || out_free;
    assign s2_free      = !s2_valid_reg || s3_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign sample_stall = !s1_free;
    assign accept       = sample_valid && s1_free;
    assign s2_move      = s2_valid_reg && s3_free;
    assign s3_move      = s3_valid_reg && out_free;
    assign det_step     = s3_move && !s3_first_reg;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stroke_reg    <= STROKE_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            required_reg  <= REQUIRED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STROKE_RANGE: stroke_reg    <= cfg_data[STROKE_W-1:0];
                CFG_TOLERANCE:    tolerance_reg <= cfg_data[TOLERANCE_W-1:0];
                CFG_REQUIRED:     required_reg  <= cfg_data[REQUIRED_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= RANGE_W'(stroke_reg) * RANGE_W'(ADC_FULL_SCALE);
        tol_reg   <= TOL_W'(tolerance_reg) * TOL_W'(ADC_FULL_SCALE);
    end

    // accumulate and average lanes
    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        logic [SUM_W:0]    acc;
        logic [PROD_W-1:0] prod;
        logic [SUM_W:0]    quot;

        always_comb
        begin
            acc = {1'b0, sum_reg[i]};
            if (sample_word.channel == CHANNEL_W'(i))
            begin
                acc = acc + (SUM_W + 1)'(sample_word.sample);
            end
            sum_next[i] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            prod        = PROD_W'(s1_sum_reg[i]) * PROD_W'(RECIP);
            quot        = prod[DIV_SHIFT +: SUM_W + 1];
            avg_next[i] = (quot > (SUM_W + 1)'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[i] <= '0;
            end
            else if (accept)
            begin
                sum_reg[i] <= sample_word.frame_end ? '0 : sum_next[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (accept && sample_word.frame_end)
            begin
                s1_sum_reg[i] <= sum_next[i];
            end
            if (s2_free)
            begin
                s2_avg_reg[i] <= avg_next[i];
            end
            if (s3_free)
            begin
                s3_avg_reg[i] <= s2_avg_reg[i];
            end
        end
    end

    // offset of each pincher from its rest angle
    always_comb
    begin
        logic signed [DIFF_W-1:0] diff_a;
        logic signed [DIFF_W-1:0] diff_b;
        diff_a    = $signed({1'b0, rest_reg[0]}) - $signed({1'b0, s2_avg_reg[PINCH_CH_A]});
        diff_b    = $signed({1'b0, rest_reg[1]}) - $signed({1'b0, s2_avg_reg[PINCH_CH_B]});
        d_next[0] = D_W'(diff_a) * DEG_PER_TURN;
        d_next[1] = D_W'(diff_b) * DEG_PER_TURN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg[0]  <= '0;
            rest_reg[1]  <= '0;
            captured_reg <= 1'b0;
            s3_first_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            s3_first_reg <= !captured_reg;
            if (!captured_reg)
            begin
                rest_reg[0]  <= s2_avg_reg[PINCH_CH_A];
                rest_reg[1]  <= s2_avg_reg[PINCH_CH_B];
                captured_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free)
        begin
            s3_d_reg[0] <= d_next[0];
            s3_d_reg[1] <= d_next[1];
        end
    end

    adcpd_detector #(
        .RANGE_W (RANGE_W),
        .TOL_W   (TOL_W)
    ) u_detector_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (det_step),
        .offset (s3_d_reg[0]),
        .range  (range_reg),
        .tol    (tol_reg),
        .status (status_a)
    );

    adcpd_detector #(
        .RANGE_W (RANGE_W),
        .TOL_W   (TOL_W)
    ) u_detector_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (det_step),
        .offset (s3_d_reg[1]),
        .range  (range_reg),
        .tol    (tol_reg),
        .status (status_b)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_free  ? (accept && sample_word.frame_end) : 1'b1;
            s2_valid_reg     <= s2_free  ? s1_valid_reg : 1'b1;
            s3_valid_reg     <= s3_free  ? s2_valid_reg : 1'b1;
            result_valid_reg <= out_free ? s3_valid_reg : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            result_word_reg.avg_ch0         <= s3_avg_reg[0];
            result_word_reg.avg_ch1         <= s3_avg_reg[1];
            result_word_reg.avg_ch2         <= s3_avg_reg[2];
            result_word_reg.avg_ch3         <= s3_avg_reg[3];
            result_word_reg.avg_ch4         <= s3_avg_reg[4];
            result_word_reg.avg_ch5         <= s3_avg_reg[5];
            result_word_reg.pinch_state_a   <= status_a.state;
            result_word_reg.pinch_state_b   <= status_b.state;
            result_word_reg.squeeze_count_a <= status_a.count;
            result_word_reg.squeeze_count_b <= status_b.count;
            result_word_reg.both_done       <= (status_a.count >= required_reg) &&
                                               (status_b.count >= required_reg);
        end
    end

endmodule

/* design/adcpd_checker.sv */
// Port-level checks for the ADC encoder pinch detector, bound to the top level.
// Depends on adcpd_pkg and adc_encoder_pinch_detector.
module adcpd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_stall,
    input adcpd_pkg::sample_word_t           sample_word,
    input logic                              result_valid,
    input logic                              result_stall,
    input adcpd_pkg::result_word_t           result_word
);
    import adcpd_pkg::*;

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample_word))
        else $error("stalled sample word changed");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_word))
        else $error("stalled result word changed");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample stalled with empty result stage");

    a_count_a: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.pinch_state_a == PINCH_SQUEEZED ||
                         result_word.pinch_state_a == PINCH_OPENING)
        |-> result_word.squeeze_count_a != '0)
        else $error("pincher a squeezed without a counted squeeze");

    a_count_b: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.pinch_state_b == PINCH_SQUEEZED ||
                         result_word.pinch_state_b == PINCH_OPENING)
        |-> result_word.squeeze_count_b != '0)
        else $error("pincher b squeezed without a counted squeeze");

endmodule

bind adc_encoder_pinch_detector adcpd_checker u_adcpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);
